// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is high
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// clocked assertion that also holds across reset
`define ASSERT_CLK_NR(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== design/hfm_pkg.sv =====
// ----------------------------------------------------------------------------
// hfm_pkg
// shared widths, constants and types of the homomorphic filter mask unit
// ----------------------------------------------------------------------------
package hfm_pkg;

   // mask geometry
   localparam int MAX_SIDE  = 1024;
   localparam int SIDE_W    = $clog2(MAX_SIDE) + 1;
   localparam int COORD_W   = 10;
   localparam int HALF_W    = SIDE_W - 1;
   localparam int D2_W      = 2 * HALF_W;

   // configuration register file
   localparam int CFG_W     = 6;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA_HIGH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA_LOW   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHARPNESS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_HEIGHT = 3'd5;

   // exponent argument t = C*D2*1e6 / (1000*D0+1)^2
   localparam int D0M_W     = 16;
   localparam int DEN_W     = 2 * D0M_W;
   localparam int MIL_W     = 20;
   localparam int NUM1_W    = CFG_W + D2_W;
   localparam int NUM_W     = NUM1_W + MIL_W;
   localparam logic [D0M_W-1:0] THOUSAND = 16'd1000;
   localparam logic [MIL_W-1:0] MILLION  = 20'd1000000;

   // Q32 arithmetic of the exponential
   localparam int Q_W          = 32;
   localparam int INT_STEPS    = 5;
   localparam int DIV_STEPS    = INT_STEPS + Q_W;
   localparam int T_W          = DIV_STEPS;
   localparam int S_W          = Q_W - 1;
   localparam int M_W          = 3;
   localparam int SERIES_STEPS = 15;
   localparam int DBL_STEPS    = 6;
   localparam int PROD_W       = 2 * S_W;
   localparam int X_W          = PROD_W - Q_W;
   localparam int Y_W          = X_W + Q_W;
   localparam int SQ_W         = 2 * Q_W;

   localparam int LANE_LAT = 2 + DIV_STEPS + 1 + 3 * SERIES_STEPS + 2 * DBL_STEPS;

   // normalization divide
   localparam int GAIN_W      = 17;
   localparam int GAIN_FRAC   = 16;
   localparam int RATIO_STEPS = GAIN_W;
   localparam int RN_W        = Q_W + GAIN_FRAC + 1;
   localparam int RATIO_LAT   = RATIO_STEPS + 1;
   localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

   localparam int FRONT_LAT = 2;
   localparam int PIPE_LAT  = FRONT_LAT + LANE_LAT + RATIO_LAT;

   typedef struct packed {
      logic                 zero;
      logic [GAIN_W-1:0]    value;
   } ratio_type;

   typedef struct packed {
      logic [CFG_W-1:0]     gamma_high;
      logic [CFG_W-1:0]     gamma_low;
      logic [CFG_W-1:0]     cutoff;
      logic [CFG_W-1:0]     sharpness;
      logic [SIDE_W-1:0]    mask_width;
      logic [SIDE_W-1:0]    mask_height;
   } cfg_type;

endpackage

// ===== design/hfm_exp_lane.sv =====
// ----------------------------------------------------------------------------
// hfm_exp_lane
// pipelined e(D2) = 1 - exp(-k*D2) in Q32: divide, range reduce, series, squaring
// ----------------------------------------------------------------------------
module hfm_exp_lane
   import hfm_pkg::*;
(
   input  logic               clock,
   input  logic               adv,
   input  logic [CFG_W-1:0]   sharpness,
   input  logic [DEN_W-1:0]   den,
   input  logic [D2_W-1:0]    d2,
   output logic [Q_W-1:0]     e_out
);

   typedef struct packed {
      logic                 sat;
      logic [NUM_W-1:0]     rem;
      logic [T_W-1:0]       quo;
   } div_type;

   typedef struct packed {
      logic                 sat;
      logic [M_W-1:0]       m;
      logic [S_W-1:0]       s;
      logic [S_W-1:0]       term;
      logic [Q_W-1:0]       acc;
   } ser_type;

   typedef struct packed {
      logic                 sat;
      logic [M_W-1:0]       m;
      logic [Q_W-1:0]       acc;
   } dbl_type;

   logic [NUM1_W-1:0] num1_ff;
   logic [NUM_W-1:0]  num_ff;

   div_type div_src [DIV_STEPS+1];
   div_type div_in  [DIV_STEPS];
   div_type div_ff  [DIV_STEPS];

   logic [T_W-1:0] t_val;
   ser_type        nrm_in;
   ser_type        nrm_ff;

   ser_type           ser_src  [SERIES_STEPS+1];
   ser_type           ser_a_ff [SERIES_STEPS];
   logic [PROD_W-1:0] prod_ff  [SERIES_STEPS];
   ser_type           ser_b_ff [SERIES_STEPS];
   logic [X_W-1:0]    x_ff     [SERIES_STEPS];
   logic [Y_W-1:0]    y_ff     [SERIES_STEPS];
   ser_type           ser_c_in [SERIES_STEPS];
   ser_type           ser_c_ff [SERIES_STEPS];

   dbl_type           dbl_src  [DBL_STEPS+1];
   dbl_type           dbl_a_ff [DBL_STEPS];
   logic [SQ_W-1:0]   sq_ff    [DBL_STEPS];
   dbl_type           dbl_b_in [DBL_STEPS];
   dbl_type           dbl_b_ff [DBL_STEPS];

   // numerator C*D2*1e6 in two multiplies
   always_ff @(posedge clock) begin
      if (adv) begin
         num1_ff <= NUM1_W'(sharpness) * NUM1_W'(d2);
         num_ff  <= NUM_W'(num1_ff) * NUM_W'(MILLION);
      end
   end

   // restoring divide: five integer bits, then 32 fraction bits
   always_comb begin
      div_src[0].sat = (num_ff >= (NUM_W'(den) << INT_STEPS));
      div_src[0].rem = num_ff;
      div_src[0].quo = '0;
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      if (k < INT_STEPS) begin : g_int
         localparam int SH = INT_STEPS - 1 - k;
         logic [NUM_W-1:0] cmp;
         always_comb begin
            cmp       = NUM_W'(den) << SH;
            div_in[k] = div_src[k];
            if (div_src[k].rem >= cmp) begin
               div_in[k].rem           = div_src[k].rem - cmp;
               div_in[k].quo[T_W-1-k]  = 1'b1;
            end
         end
      end else begin : g_frac
         logic [DEN_W:0] r2;
         always_comb begin
            r2        = {div_src[k].rem[DEN_W-1:0], 1'b0};
            div_in[k] = div_src[k];
            if (r2 >= {1'b0, den}) begin
               r2                      = r2 - {1'b0, den};
               div_in[k].quo[T_W-1-k]  = 1'b1;
            end
            div_in[k].rem = NUM_W'(r2);
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[k] <= div_in[k];
         end
      end

      assign div_src[k+1] = div_ff[k];
   end

   // range reduction: least shift that brings t below one half
   assign t_val = div_ff[DIV_STEPS-1].quo;

   always_comb begin
      nrm_in.sat = div_ff[DIV_STEPS-1].sat;
      priority if (t_val[36]) nrm_in.m = 3'd6;
      else if (t_val[35])     nrm_in.m = 3'd5;
      else if (t_val[34])     nrm_in.m = 3'd4;
      else if (t_val[33])     nrm_in.m = 3'd3;
      else if (t_val[32])     nrm_in.m = 3'd2;
      else if (t_val[31])     nrm_in.m = 3'd1;
      else                    nrm_in.m = 3'd0;
      nrm_in.s    = S_W'(t_val >> nrm_in.m);
      nrm_in.term = nrm_in.s;
      nrm_in.acc  = Q_W'(nrm_in.s);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nrm_ff <= nrm_in;
      end
   end

   assign ser_src[0] = nrm_ff;

   // series: each step is multiply, reciprocal multiply, correct and accumulate
   for (genvar j = 0; j < SERIES_STEPS; j++) begin : g_ser
      localparam logic [X_W-1:0] DIVISOR = X_W'(j + 2);
      localparam logic [Q_W-1:0] RECIP   = Q_W'(64'h1_0000_0000 / (j + 2));
      logic [X_W-1:0] q_est;
      logic [X_W-1:0] rem_est;
      logic [X_W-1:0] new_term;

      always_ff @(posedge clock) begin
         if (adv) begin
            ser_a_ff[j] <= ser_src[j];
            prod_ff[j]  <= PROD_W'(ser_src[j].term) * PROD_W'(ser_src[j].s);
            ser_b_ff[j] <= ser_a_ff[j];
            x_ff[j]     <= prod_ff[j][PROD_W-1:Q_W];
            y_ff[j]     <= Y_W'(prod_ff[j][PROD_W-1:Q_W]) * Y_W'(RECIP);
            ser_c_ff[j] <= ser_c_in[j];
         end
      end

      // estimate is low by at most one
      always_comb begin
         q_est    = y_ff[j][Y_W-1:Q_W];
         rem_est  = x_ff[j] - X_W'(q_est * DIVISOR);
         new_term = (rem_est >= DIVISOR) ? q_est + 1'b1 : q_est;
         ser_c_in[j]      = ser_b_ff[j];
         ser_c_in[j].term = S_W'(new_term);
         if ((j % 2) == 0) begin
            ser_c_in[j].acc = ser_b_ff[j].acc - Q_W'(new_term);
         end else begin
            ser_c_in[j].acc = ser_b_ff[j].acc + Q_W'(new_term);
         end
      end

      assign ser_src[j+1] = ser_c_ff[j];
   end

   always_comb begin
      dbl_src[0].sat = ser_src[SERIES_STEPS].sat;
      dbl_src[0].m   = ser_src[SERIES_STEPS].m;
      dbl_src[0].acc = ser_src[SERIES_STEPS].acc;
   end

   // argument doubling: e = 2e - e*e, applied m times
   for (genvar j = 0; j < DBL_STEPS; j++) begin : g_dbl
      localparam logic [M_W-1:0] STEP = M_W'(j);
      logic [Q_W+1:0] twice;

      always_comb begin
         twice       = {1'b0, dbl_a_ff[j].acc, 1'b0} - (Q_W+2)'(sq_ff[j][SQ_W-1:Q_W]);
         dbl_b_in[j] = dbl_a_ff[j];
         if (STEP < dbl_a_ff[j].m) begin
            dbl_b_in[j].acc = (twice[Q_W+1:Q_W] != 2'b00) ? '1 : twice[Q_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dbl_a_ff[j] <= dbl_src[j];
            sq_ff[j]    <= SQ_W'(dbl_src[j].acc) * SQ_W'(dbl_src[j].acc);
            dbl_b_ff[j] <= dbl_b_in[j];
         end
      end

      assign dbl_src[j+1] = dbl_b_ff[j];
   end

   assign e_out = dbl_src[DBL_STEPS].sat ? '1 : dbl_src[DBL_STEPS].acc;

endmodule

// ===== design/hfm_ratio_div.sv =====
// ----------------------------------------------------------------------------
// hfm_ratio_div
// pipelined rounded quotient e(D2) / e(Dmax2) in Q16, clamped to one
// ----------------------------------------------------------------------------
module hfm_ratio_div
   import hfm_pkg::*;
(
   input  logic               clock,
   input  logic               adv,
   input  logic [Q_W-1:0]     ed,
   input  logic [Q_W-1:0]     emax,
   output ratio_type          ratio
);

   typedef struct packed {
      logic                     sat;
      logic                     zero;
      logic [RN_W-1:0]          rem;
      logic [RATIO_STEPS-1:0]   quo;
      logic [Q_W-1:0]           den;
   } rdiv_type;

   rdiv_type pre_in;
   rdiv_type pre_ff;
   rdiv_type step_src [RATIO_STEPS+1];
   rdiv_type step_in  [RATIO_STEPS];
   rdiv_type step_ff  [RATIO_STEPS];
   rdiv_type last;

   // rounded numerator and overflow check
   always_comb begin
      pre_in.rem  = (RN_W'(ed) << GAIN_FRAC) + RN_W'(emax >> 1);
      pre_in.sat  = (pre_in.rem >= (RN_W'(emax) << RATIO_STEPS));
      pre_in.zero = (emax == '0);
      pre_in.quo  = '0;
      pre_in.den  = emax;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pre_ff <= pre_in;
      end
   end

   assign step_src[0] = pre_ff;

   // one quotient bit per stage
   for (genvar k = 0; k < RATIO_STEPS; k++) begin : g_step
      localparam int SH = RATIO_STEPS - 1 - k;
      logic [RN_W-1:0] cmp;

      always_comb begin
         cmp        = RN_W'(step_src[k].den) << SH;
         step_in[k] = step_src[k];
         if (step_src[k].rem >= cmp) begin
            step_in[k].rem     = step_src[k].rem - cmp;
            step_in[k].quo[SH] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            step_ff[k] <= step_in[k];
         end
      end

      assign step_src[k+1] = step_ff[k];
   end

   assign last        = step_src[RATIO_STEPS];
   assign ratio.zero  = last.zero;
   assign ratio.value = (last.sat || (last.quo > GAIN_ONE)) ? GAIN_ONE : last.quo;

endmodule

// ===== design/homomorphic_filter_mask_unit.sv =====
// ----------------------------------------------------------------------------
// homomorphic_filter_mask_unit
// min-max normalized homomorphic transfer value per frequency coordinate
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one (row, col) coordinate per beat; rsp channel
//   returns one Q1.16 gain per beat, in order (65536 is 1.0).
//   Each beat travels a fixed pipeline of 118 register stages: 2 for the
//   distance, 97 in each exponential lane (37 of them a bit-per-stage
//   divider), 18 for the normalizing divide, and the output register.
//   Throughput is one beat per cycle unless a held output beat stalls the
//   pipe; both lanes and all three dividers are fully pipelined, so
//   nothing iterates.
//   csr writes are registered; write them only while the pipe is empty.
//   Reset (synchronous) empties the pipeline and loads the default
//   registers: gains 10/5, cutoff 10, sharpness 5, mask 640 x 480.
//   While rsp_stall holds a waiting beat, the whole pipeline freezes and
//   req_stall rises; no beat is dropped or repeated.
// ----------------------------------------------------------------------------
module homomorphic_filter_mask_unit
   import hfm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COORD_W-1:0]    req_row,
   input  logic [COORD_W-1:0]    req_col,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [GAIN_W-1:0]     rsp_gain,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DAT_W-1:0]  csr_data
);

   cfg_type cfg_ff;

   logic                adv;
   logic [PIPE_LAT-1:0] vld_ff;
   logic [PIPE_LAT-1:0] vld_in;

   logic [SIDE_W-1:0]   w_side;
   logic [SIDE_W-1:0]   h_side;
   logic [COORD_W-1:0]  r_last;
   logic [COORD_W-1:0]  c_last;
   logic [COORD_W-1:0]  r_cl;
   logic [COORD_W-1:0]  c_cl;
   logic [HALF_W-1:0]   cy;
   logic [HALF_W-1:0]   cx;
   logic [HALF_W-1:0]   dy_in;
   logic [HALF_W-1:0]   dx_in;

   logic [HALF_W-1:0]   dy_ff;
   logic [HALF_W-1:0]   dx_ff;
   logic [HALF_W-1:0]   cy_ff;
   logic [HALF_W-1:0]   cx_ff;
   logic [D2_W-1:0]     d2_ff;
   logic [D2_W-1:0]     dmax2_ff;

   logic [D0M_W-1:0]    d0m;
   logic [DEN_W-1:0]    den_ff;

   logic [Q_W-1:0]      ed;
   logic [Q_W-1:0]      emax;
   ratio_type           ratio;

   logic                rsp_valid_ff;
   logic [GAIN_W-1:0]   rsp_gain_ff;
   logic [GAIN_W-1:0]   rsp_gain_in;

   // register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gamma_high  <= 6'd10;
         cfg_ff.gamma_low   <= 6'd5;
         cfg_ff.cutoff      <= 6'd10;
         cfg_ff.sharpness   <= 6'd5;
         cfg_ff.mask_width  <= 11'd640;
         cfg_ff.mask_height <= 11'd480;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_GAMMA_HIGH:  cfg_ff.gamma_high  <= csr_data[CFG_W-1:0];
            CSR_GAMMA_LOW:   cfg_ff.gamma_low   <= csr_data[CFG_W-1:0];
            CSR_CUTOFF:      cfg_ff.cutoff      <= csr_data[CFG_W-1:0];
            CSR_SHARPNESS:   cfg_ff.sharpness   <= csr_data[CFG_W-1:0];
            CSR_MASK_WIDTH:  cfg_ff.mask_width  <= csr_data[SIDE_W-1:0];
            CSR_MASK_HEIGHT: cfg_ff.mask_height <= csr_data[SIDE_W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipe moves when the output register is free or being taken
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign vld_in    = {vld_ff[PIPE_LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[PIPE_LAT-1];
      end
   end

   // side clamp, coordinate clamp and distance from centre
   always_comb begin
      w_side = (cfg_ff.mask_width == '0) ? SIDE_W'(1) :
               (cfg_ff.mask_width > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : cfg_ff.mask_width;
      h_side = (cfg_ff.mask_height == '0) ? SIDE_W'(1) :
               (cfg_ff.mask_height > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : cfg_ff.mask_height;
      cx     = w_side[SIDE_W-1:1];
      cy     = h_side[SIDE_W-1:1];
      c_last = COORD_W'(w_side - 1'b1);
      r_last = COORD_W'(h_side - 1'b1);
      r_cl   = (req_row > r_last) ? r_last : req_row;
      c_cl   = (req_col > c_last) ? c_last : req_col;
      dy_in  = (r_cl >= cy) ? r_cl - cy : cy - r_cl;
      dx_in  = (c_cl >= cx) ? c_cl - cx : cx - c_cl;
   end

   // squared distances of the item and of the corner
   always_ff @(posedge clock) begin
      if (adv) begin
         dy_ff    <= dy_in;
         dx_ff    <= dx_in;
         cy_ff    <= cy;
         cx_ff    <= cx;
         d2_ff    <= D2_W'(dy_ff) * D2_W'(dy_ff) + D2_W'(dx_ff) * D2_W'(dx_ff);
         dmax2_ff <= D2_W'(cy_ff) * D2_W'(cy_ff) + D2_W'(cx_ff) * D2_W'(cx_ff);
      end
   end

   // divisor (1000*D0 + 1)^2 follows the register file
   assign d0m = D0M_W'(cfg_ff.cutoff) * THOUSAND + 1'b1;

   always_ff @(posedge clock) begin
      den_ff <= DEN_W'(d0m) * DEN_W'(d0m);
   end

   hfm_exp_lane u_lane_item (
      .clock     (clock),
      .adv       (adv),
      .sharpness (cfg_ff.sharpness),
      .den       (den_ff),
      .d2        (d2_ff),
      .e_out     (ed)
   );

   hfm_exp_lane u_lane_corner (
      .clock     (clock),
      .adv       (adv),
      .sharpness (cfg_ff.sharpness),
      .den       (den_ff),
      .d2        (dmax2_ff),
      .e_out     (emax)
   );

   hfm_ratio_div u_ratio (
      .clock (clock),
      .adv   (adv),
      .ed    (ed),
      .emax  (emax),
      .ratio (ratio)
   );

   // flat mask or a zero corner term gives zero, inverted gains flip the ratio
   always_comb begin
      if ((cfg_ff.gamma_high == cfg_ff.gamma_low) || ratio.zero) begin
         rsp_gain_in = '0;
      end else if (cfg_ff.gamma_high > cfg_ff.gamma_low) begin
         rsp_gain_in = ratio.value;
      end else begin
         rsp_gain_in = GAIN_ONE - ratio.value;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_gain_ff <= rsp_gain_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_gain  = rsp_gain_ff;

endmodule

// ===== design/hfm_checker.sv =====
// ----------------------------------------------------------------------------
// hfm_checker
// port-level checks of the homomorphic filter mask unit
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hfm_checker
   import hfm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_stall,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [GAIN_W-1:0]     rsp_gain
);

   // gain never exceeds one
   `ASSERT_CLK(a_gain_range, rsp_valid |-> (rsp_gain <= GAIN_ONE), "gain above one")

   // input backs up only behind a held output beat
   `ASSERT_CLK_NR(a_stall_cause, req_stall |-> (rsp_valid && rsp_stall), "stall without held beat")

   // reset empties the output
   `ASSERT_CLK_NR(a_reset_empty, reset |=> !rsp_valid, "beat after reset")

   // held beat stays put
   `ASSERT_CLK(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_gain)), "held beat changed")

endmodule

bind homomorphic_filter_mask_unit hfm_checker u_hfm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_gain  (rsp_gain)
);

// ===== bench/homomorphic_filter_mask_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// homomorphic_filter_mask_unit_tb
// Drives (row, col) coordinates in bursts through several register settings.
// Each coordinate's normalized Q1.16 gain is predicted here and compared
// in order with the gains returned under random back-pressure in most phases.
// ----------------------------------------------------------------------------
module homomorphic_filter_mask_unit_tb;
   import hfm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int NUM_PHASES  = 11;

   typedef struct {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } coord_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [COORD_W-1:0]    req_row;
   logic [COORD_W-1:0]    req_col;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [GAIN_W-1:0]     rsp_gain;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DAT_W-1:0]  csr_data;

   // predictor copy of the register file
   bit [5:0]  gh_reg, gl_reg, cutoff_reg, sharp_reg;
   bit [10:0] width_reg, height_reg;

   coord_type          coord_q[$];
   logic [GAIN_W-1:0]  gain_q[$];
   int                 error_count;
   int                 stall_pct;
   int                 burst_left;
   int                 gap_left;
   int                 cycle_count;

   homomorphic_filter_mask_unit dut (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // 1 - exp(-k*d2) in Q32
   function automatic bit [63:0] exp_deficit(bit [63:0] d2);
      bit [63:0] d0m, den, num, q, rem, t, s, term, acc;
      int m;
      d0m = 64'(cutoff_reg) * 1000 + 1;
      den = d0m * d0m;
      num = 64'(sharp_reg) * d2 * 64'd1000000;
      q   = num / den;
      rem = num % den;
      if (q >= 32) return 64'hFFFF_FFFF;
      t = (q << 32) + ((rem << 32) / den);
      m = 0;
      while ((t >> m) >= 64'h8000_0000) m++;
      s = t >> m;
      term = s;
      acc  = 0;
      // alternating series, then repeated doubling
      for (int n = 1; n <= 16; n++) begin
         if (n % 2 == 1) acc += term;
         else acc -= term;
         term = ((term * s) >> 32) / (n + 1);
      end
      if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
      while (m > 0) begin
         acc = 2 * acc - ((acc * acc) >> 32);
         if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
         m--;
      end
      return acc;
   endfunction

   function automatic logic [GAIN_W-1:0] predict_gain(coord_type c);
      bit [63:0] w, h, r, k, cy, cx, dy, dx, d2, dmax2, emax, ed, ratio, g;
      w = (width_reg == 0) ? 1 : (width_reg > MAX_SIDE) ? MAX_SIDE : width_reg;
      h = (height_reg == 0) ? 1 : (height_reg > MAX_SIDE) ? MAX_SIDE : height_reg;
      r = c.row;
      k = c.col;
      if (r > h - 1) r = h - 1;
      if (k > w - 1) k = w - 1;
      cy = h / 2;
      cx = w / 2;
      dy = (r >= cy) ? r - cy : cy - r;
      dx = (k >= cx) ? k - cx : cx - k;
      d2 = dy * dy + dx * dx;
      dmax2 = cy * cy + cx * cx;
      g = 0;
      if (gh_reg != gl_reg) begin
         emax = exp_deficit(dmax2);
         if (emax != 0) begin
            ed = exp_deficit(d2);
            ratio = (ed * 65536 + emax / 2) / emax;
            if (ratio > 65536) ratio = 65536;
            g = (gh_reg > gl_reg) ? ratio : 65536 - ratio;
         end
      end
      return g[GAIN_W-1:0];
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value[CSR_DAT_W-1:0];
      case (idx)
         CSR_GAMMA_HIGH:  gh_reg     = value[5:0];
         CSR_GAMMA_LOW:   gl_reg     = value[5:0];
         CSR_CUTOFF:      cutoff_reg = value[5:0];
         CSR_SHARPNESS:   sharp_reg  = value[5:0];
         CSR_MASK_WIDTH:  width_reg  = value[10:0];
         CSR_MASK_HEIGHT: height_reg = value[10:0];
         default: ;
      endcase
   endtask

   task automatic push_coord(int row, int col);
      coord_type c;
      c.row = row[COORD_W-1:0];
      c.col = col[COORD_W-1:0];
      coord_q.insert(coord_q.size(), c);
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (coord_q.size() != 0 || req_valid || gain_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // stimulus and phase sequencing
   initial begin
      int settings[NUM_PHASES][6] = '{
         '{10, 5, 10, 5, 640, 480},
         '{50, 0, 0, 50, 1024, 1024},
         '{0, 50, 50, 1, 64, 48},
         '{7, 7, 10, 5, 640, 480},
         '{20, 3, 10, 0, 640, 480},
         '{63, 0, 63, 63, 2047, 0},
         '{5, 6, 1, 63, 1, 1},
         '{30, 10, 3, 20, 1023, 17},
         '{0, 63, 25, 25, 200, 1000},
         '{12, 40, 0, 0, 2, 3},
         '{45, 2, 5, 40, 33, 1024}
      };
      int hmax, wmax;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_row      <= '0;
      req_col      <= '0;
      rsp_stall    <= 1'b0;
      csr_write_en <= 1'b0;
      csr_index    <= CSR_GAMMA_HIGH;
      csr_data     <= '0;
      error_count  = 0;
      stall_pct    = 0;
      gh_reg = 10; gl_reg = 5; cutoff_reg = 10; sharp_reg = 5;
      width_reg = 640; height_reg = 480;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: corners, centre, edges, beyond the mask, bit patterns
      push_coord(0, 0);
      push_coord(1023, 1023);
      push_coord(0, 1023);
      push_coord(1023, 0);
      push_coord(240, 320);
      push_coord(239, 319);
      push_coord(479, 639);
      push_coord(480, 640);
      push_coord(241, 321);
      push_coord(10'h2AA, 10'h155);
      push_coord(10'h155, 10'h2AA);
      push_coord(0, 320);
      push_coord(240, 0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         // phase 0 runs on the reset defaults
         if (p > 0) begin
            wait_drained();
            write_reg(CSR_GAMMA_HIGH, settings[p][0]);
            write_reg(CSR_GAMMA_LOW, settings[p][1]);
            write_reg(CSR_CUTOFF, settings[p][2]);
            write_reg(CSR_SHARPNESS, settings[p][3]);
            write_reg(CSR_MASK_WIDTH, settings[p][4]);
            write_reg(CSR_MASK_HEIGHT, settings[p][5]);
            @(posedge clock);
            csr_write_en <= 1'b0;
            push_coord(0, 0);
            push_coord(1023, 1023);
         end
         stall_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 30 : 70;
         hmax = (height_reg == 0) ? 0 : (height_reg > 1024) ? 1023 : height_reg - 1;
         wmax = (width_reg == 0) ? 0 : (width_reg > 1024) ? 1023 : width_reg - 1;
         // mostly inside the mask, some anywhere in the field range
         for (int i = 0; i < 42; i++) begin
            if ($urandom_range(0, 4) == 0)
               push_coord($urandom_range(0, 1023), $urandom_range(0, 1023));
            else
               push_coord($urandom_range(0, hmax), $urandom_range(0, wmax));
         end
      end

      wait_drained();
      repeat (150) @(posedge clock);
      if (error_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // request driver: bursts with random gaps
   always @(posedge clock) begin
      coord_type c;
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (coord_q.size() != 0) begin
            c = coord_q.pop_front();
            req_valid <= 1'b1;
            req_row   <= c.row;
            req_col   <= c.col;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall pattern
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // monitor: predict on request beats, check on response beats
   always @(posedge clock) begin
      coord_type c;
      logic [GAIN_W-1:0] want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            c.row = req_row;
            c.col = req_col;
            gain_q.insert(gain_q.size(), predict_gain(c));
         end
         if (rsp_valid && !rsp_stall) begin
            if (gain_q.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected gain beat: got %0d", rsp_gain);
            end else begin
               want = gain_q.pop_front();
               if (rsp_gain !== want) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("gain mismatch: expected %0d got %0d", want, rsp_gain);
               end
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial cycle_count = 0;

endmodule
